FILE: hdl/sktl_pkg.sv
// sktl_pkg: widths, register indexes and defaults for the sorted key table lookup
// no dependencies

package sktl_pkg;

    localparam int WORD_W      = 16;
    localparam int KEY_W       = 3 * WORD_W;
    localparam int NUM_W       = 10;
    localparam int BASE_W      = 16;
    localparam int STRIDE_W    = 8;
    localparam int COUNT_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_OUT_W  = 16;

    localparam int DEFAULT_MAX_ENTRIES = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd2;

    localparam logic [BASE_W-1:0]   BASE_RESET   = 16'd0;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd6;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 12'd0;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

endpackage

FILE: hdl/sorted_key_table_lookup.sv
// sorted_key_table_lookup: key store memory with a binary or linear search sequencer
// depends on sktl_pkg
//
// usage
// - command channel: a word is taken at a clock edge with start high and busy low.
//   cmd load writes the three key words into entry entry_number (ignored when it is
//   beyond the store); cmd lookup searches 1..|entry_count| capped at the depth
// - entry_count > 0: binary search over a sorted table; <= 0: linear search
// - result channel: done is high for exactly one cycle with found and entry_address;
//   a miss gives found 0 and address 0. loads give no result
// - a load is written at the edge that takes it; busy stays low
// - a lookup first checks the search range, then makes p probes: up to
//   ceil(log2(n+1)) for binary search (11 for 1024 entries), up to n for linear
//   search, and 0 when the search range is empty. done rises in the cycle after the
//   last probe, and the next word can be taken in that same cycle
// - the rate is set by the single read port of the key store: one entry read
//   and compared per cycle
// - configuration: cfg_write with cfg_index and cfg_data writes a register at once
// - reset puts the config registers at their defaults and clears the sequencer; the
//   key store holds no reset value and must be loaded before it is searched
// - the receiver cannot stall; results are never held

module sorted_key_table_lookup
#(
    parameter int MAX_ENTRIES = sktl_pkg::DEFAULT_MAX_ENTRIES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sktl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sktl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [sktl_pkg::NUM_W-1:0]       entry_number,
    input  logic [sktl_pkg::WORD_W-1:0]      key_first_word,
    input  logic [sktl_pkg::WORD_W-1:0]      key_second_word,
    input  logic [sktl_pkg::WORD_W-1:0]      key_third_word,
    output logic                             done,
    output logic                             found,
    output logic [sktl_pkg::ADDR_OUT_W-1:0]  entry_address
);

    import sktl_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = CW + 1;
    localparam int PW = AW + STRIDE_W;
    localparam logic [COUNT_W:0] MAX_N = (COUNT_W + 1)'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_PROBE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [BASE_W-1:0]    base_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [KEY_W-1:0]     key_store [MAX_ENTRIES];
    logic [KEY_W-1:0]     rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;

    logic [KEY_W-1:0]     key_reg;
    logic                 linear_reg;
    logic [BW-1:0]        bottom_reg, bottom_next;
    logic [BW-1:0]        top_reg, top_next;
    logic [BW-1:0]        mid_reg, mid_next;

    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [ADDR_OUT_W-1:0] address_reg, address_next;

    logic                 accept;
    logic                 load_ok;
    logic [COUNT_W:0]     count_ext;
    logic [COUNT_W:0]     count_mag;
    logic [CW-1:0]        count_n;
    logic                 count_linear;

    logic [WORD_W-1:0]    e0, e1, e2, k0, k1, k2;
    logic                 eq0, eq1, eq2, hit, less;
    logic [BW-1:0]        nb, nt;
    logic                 more;
    logic [AW-1:0]        hit_index;
    logic [PW-1:0]        hit_offset;
    logic [ADDR_OUT_W-1:0] hit_address;

    function automatic logic [BW-1:0] mid_of(input logic [BW-1:0] b, input logic [BW-1:0] t,
                                             input logic lin);
        logic [BW:0] sum;
        sum = {1'b0, b} + {1'b0, t};
        return lin ? b : sum[BW:1];
    endfunction

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign load_ok = ((CW + NUM_W)'(entry_number) < (CW + NUM_W)'(MAX_ENTRIES));

    // clamp the count magnitude to the store depth
    assign count_ext    = {count_reg[COUNT_W-1], count_reg};
    assign count_mag    = count_reg[COUNT_W-1] ? (~count_ext + 1'b1) : count_ext;
    assign count_n      = CW'((count_mag > MAX_N) ? MAX_N : count_mag);
    assign count_linear = count_reg[COUNT_W-1] || (count_reg == '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            stride_reg <= STRIDE_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENTRIES_BASE: base_reg   <= cfg_data[BASE_W-1:0];
                REG_ENTRY_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                REG_ENTRY_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // key store: one write port, one registered read port; no write while searching
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_LOAD && load_ok)
        begin
            key_store[AW'(entry_number)] <= {key_first_word, key_second_word, key_third_word};
        end
        if (rd_en)
        begin
            rd_data_reg <= key_store[rd_addr];
        end
    end

    // compare of the probed entry
    assign e0 = rd_data_reg[KEY_W-1 -: WORD_W];
    assign e1 = rd_data_reg[WORD_W +: WORD_W];
    assign e2 = rd_data_reg[WORD_W-1:0];
    assign k0 = key_reg[KEY_W-1 -: WORD_W];
    assign k1 = key_reg[WORD_W +: WORD_W];
    assign k2 = key_reg[WORD_W-1:0];
    assign eq0  = (e0 == k0);
    assign eq1  = (e1 == k1);
    assign eq2  = (e2 == k2);
    assign hit  = eq0 && eq1 && eq2;
    assign less = (e0 < k0) || (eq0 && (e1 < k1)) || (eq0 && eq1 && (e2 < k2));

    assign nb   = (linear_reg || less) ? (mid_reg + BW'(1)) : bottom_reg;
    assign nt   = (linear_reg || less) ? top_reg : (mid_reg - BW'(1));
    assign more = (nb <= nt);

    assign hit_index   = AW'(mid_reg - BW'(1));
    assign hit_offset  = PW'(hit_index) * PW'(stride_reg);
    assign hit_address = base_reg + ADDR_OUT_W'(hit_offset);

    always_comb
    begin
        state_next   = state_reg;
        bottom_next  = bottom_reg;
        top_next     = top_reg;
        mid_next     = mid_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        address_next = address_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(mid_of(bottom_reg, top_reg, linear_reg) - BW'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_LOOKUP)
                begin
                    bottom_next = BW'(1);
                    top_next    = BW'(count_n);
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (bottom_reg <= top_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid_of(bottom_reg, top_reg, linear_reg);
                    state_next = ST_PROBE;
                end
                else
                begin
                    done_next    = 1'b1;
                    found_next   = 1'b0;
                    address_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (hit)
                begin
                    done_next    = 1'b1;
                    found_next   = 1'b1;
                    address_next = hit_address;
                    state_next   = ST_IDLE;
                end
                else if (more)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = AW'(mid_of(nb, nt, linear_reg) - BW'(1));
                    mid_next    = mid_of(nb, nt, linear_reg);
                    bottom_next = nb;
                    top_next    = nt;
                end
                else
                begin
                    done_next    = 1'b1;
                    found_next   = 1'b0;
                    address_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            bottom_reg <= BW'(1);
            top_reg    <= '0;
            mid_reg    <= BW'(1);
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            bottom_reg <= bottom_next;
            top_reg    <= top_next;
            mid_reg    <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        address_reg <= address_next;
        if (accept && cmd == CMD_LOOKUP)
        begin
            key_reg    <= {key_first_word, key_second_word, key_third_word};
            linear_reg <= count_linear;
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign entry_address = address_reg;

    a_done_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE) && ($past(state_reg) != ST_IDLE))
        else $error("result strobe without a finished search");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> (address_reg == '0))
        else $error("miss with nonzero address");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |->
            (bottom_reg <= mid_reg) && (mid_reg <= top_reg) && (mid_reg != '0))
        else $error("probe outside search bounds");

    a_probe_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> $past(rd_en))
        else $error("compare without a read");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for sorted_key_table_lookup, directed table checks then random phases
// predicts each lookup from a local copy of the key store and registers; depends on sktl_pkg

module tb;
    import sktl_pkg::*;

    localparam int MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
    localparam int ITEM_TARGET = 1550;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [63:0] KEY_MAX = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic              cmd;
        logic [NUM_W-1:0]  num;
        logic [KEY_W-1:0]  key;
    } cmd_word_t;

    typedef struct packed {
        logic                  found;
        logic [ADDR_OUT_W-1:0] addr;
    } lookup_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  cmd = CMD_LOAD;
    logic [NUM_W-1:0]      entry_number = '0;
    logic [WORD_W-1:0]     key_first_word = '0;
    logic [WORD_W-1:0]     key_second_word = '0;
    logic [WORD_W-1:0]     key_third_word = '0;
    logic                  done;
    logic                  found;
    logic [ADDR_OUT_W-1:0] entry_address;

    cmd_word_t      cmd_words_waiting [$];
    lookup_result_t lookup_results_due [$];
    cmd_word_t      next_word;
    lookup_result_t due_now;

    logic [KEY_W-1:0]          key_mem [0:MAX_ENTRIES-1];
    logic [KEY_W-1:0]          phase_keys [0:MAX_ENTRIES-1];
    logic [BASE_W-1:0]         base_q = BASE_RESET;
    logic [STRIDE_W-1:0]       stride_q = STRIDE_RESET;
    logic signed [COUNT_W-1:0] count_q = COUNT_RESET;

    logic                  took = 1'b0;
    logic                  hit_p;
    logic [ADDR_OUT_W-1:0] addr_p;
    int                    sender_idle_pct = 0;
    int                    mismatches = 0;
    int                    items_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sorted_key_table_lookup i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .entry_number    (entry_number),
        .key_first_word  (key_first_word),
        .key_second_word (key_second_word),
        .key_third_word  (key_third_word),
        .done            (done),
        .found           (found),
        .entry_address   (entry_address)
    );

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("%0t: %s got %h want %h", $time, field, got, want);
    endtask

    function automatic void search_table(input logic [KEY_W-1:0] key, output logic hit,
                                         output logic [ADDR_OUT_W-1:0] addr);
        int cnt, lo, hi, mid, n, k, pos;
        logic [31:0] a;
        cnt = count_q;
        hit = 1'b0;
        addr = '0;
        pos = 0;
        if (cnt > 0)
        begin
            lo = 1;
            hi = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;
            while (lo <= hi && !hit)
            begin
                mid = (lo + hi) / 2;
                if (key_mem[mid - 1] == key)
                begin
                    hit = 1'b1;
                    pos = mid - 1;
                end
                else if (key_mem[mid - 1] < key)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
        end
        else
        begin
            n = (-cnt > MAX_ENTRIES) ? MAX_ENTRIES : -cnt;
            for (k = 0; k < n && !hit; k++)
                if (key_mem[k] == key)
                begin
                    hit = 1'b1;
                    pos = k;
                end
        end
        if (hit)
        begin
            a = base_q + pos * stride_q;
            addr = a[ADDR_OUT_W-1:0];
        end
    endfunction

    // driver: one word on the command port, held until taken
    always @(negedge clk)
    begin
        if (!start || took)
        begin
            if (rst_n && cmd_words_waiting.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                next_word = cmd_words_waiting.pop_front();
                start <= 1'b1;
                cmd <= next_word.cmd;
                entry_number <= next_word.num;
                key_first_word <= next_word.key[47:32];
                key_second_word <= next_word.key[31:16];
                key_third_word <= next_word.key[15:0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: checks results, then predicts the word taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (lookup_results_due.size() == 0)
                    report_mismatch("result with no lookup pending", {15'd0, found}, 16'd0);
                else
                begin
                    due_now = lookup_results_due.pop_front();
                    if (found !== due_now.found)
                        report_mismatch("found", {15'd0, found}, {15'd0, due_now.found});
                    if (entry_address !== due_now.addr)
                        report_mismatch("entry_address", entry_address, due_now.addr);
                end
            end
            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                begin
                    if (int'(entry_number) < MAX_ENTRIES)
                        key_mem[entry_number] = {key_first_word, key_second_word,
                                                 key_third_word};
                end
                else
                begin
                    search_table({key_first_word, key_second_word, key_third_word},
                                 hit_p, addr_p);
                    lookup_results_due.push_back({hit_p, addr_p});
                end
            end
        end
        took <= rst_n && start && !busy;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        logic [KEY_W-1:0] k;
        int w;
        r = rand64();
        k = r[KEY_W-1:0];
        if ($urandom_range(4) == 0)
            for (w = 0; w < 3; w++)
                case ($urandom_range(2))
                    0: k[w*16 +: 16] = 16'h0000;
                    1: k[w*16 +: 16] = 16'hFFFF;
                    default: ;
                endcase
        return k;
    endfunction

    // stored key, neighbor of one, one word changed, or anything
    function automatic logic [KEY_W-1:0] pick_probe(input int n);
        logic [KEY_W-1:0] k;
        int r;
        k = phase_keys[$urandom_range(n - 1)];
        r = $urandom_range(99);
        if (r >= 90)
            k = rand_key();
        else if (r >= 80)
            k[16*$urandom_range(2) +: 16] = 16'($urandom());
        else if (r >= 72)
            k = k + 48'd1;
        else if (r >= 65)
            k = k - 48'd1;
        return k;
    endfunction

    // ascending keys, steps small enough to share leading words at times
    task automatic fill_sorted(input int n, input bit pin_ends);
        logic [63:0] prev, room, inc;
        int i, r;
        room = KEY_MAX / n;
        prev = pin_ends ? 64'd0 : rand64() % room;
        phase_keys[0] = prev[KEY_W-1:0];
        for (i = 1; i < n; i++)
        begin
            room = (KEY_MAX - prev) / (n - i);
            r = $urandom_range(99);
            if (r < 35)
                inc = 1 + rand64() % ((room < 3) ? room : 64'd3);
            else if (r < 60)
                inc = 1 + rand64() % ((room < 65535) ? room : 64'd65535);
            else
                inc = 1 + rand64() % room;
            prev = prev + inc;
            phase_keys[i] = prev[KEY_W-1:0];
        end
        if (pin_ends)
            phase_keys[n - 1] = KEY_MAX[KEY_W-1:0];
    endtask

    task automatic queue_word(input logic c, input logic [NUM_W-1:0] num,
                              input logic [KEY_W-1:0] key);
        cmd_words_waiting.push_back({c, num, key});
        items_sent++;
    endtask

    task automatic wait_idle();
        while (cmd_words_waiting.size() != 0 || start || lookup_results_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ENTRIES_BASE: base_q = data[BASE_W-1:0];
            REG_ENTRY_STRIDE: stride_q = data[STRIDE_W-1:0];
            REG_ENTRY_COUNT:  count_q = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_regs(input logic [BASE_W-1:0] base, input logic [STRIDE_W-1:0] stride,
                            input logic [COUNT_W-1:0] cnt);
        wait_idle();
        write_reg(REG_ENTRIES_BASE, base);
        write_reg(REG_ENTRY_STRIDE, {8'($urandom()), stride});
        write_reg(REG_ENTRY_COUNT, {4'($urandom()), cnt});
    endtask

    initial
    begin
        int i, n, m, r, kind, phase;
        logic [BASE_W-1:0] base;
        logic [STRIDE_W-1:0] stride;
        logic [COUNT_W-1:0] cnt;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero count after reset: always a miss
        queue_word(CMD_LOOKUP, 10'h3FF, 48'h0);

        phase_keys[0] = 48'h0000_0000_0000;
        phase_keys[1] = 48'h0000_0000_FFFF;
        phase_keys[2] = 48'h0000_FFFF_0000;
        phase_keys[3] = 48'h1234_5678_9ABC;
        phase_keys[4] = 48'h8000_0000_0001;
        phase_keys[5] = 48'hFFFF_0000_0000;
        phase_keys[6] = 48'hFFFF_FFFF_FFFE;
        phase_keys[7] = 48'hFFFF_FFFF_FFFF;
        for (i = 0; i < 8; i++)
            queue_word(CMD_LOAD, 10'(i), phase_keys[i]);

        // base and stride keep their reset values here
        wait_idle();
        write_reg(REG_ENTRY_COUNT, 16'h0008);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[0]);
        queue_word(CMD_LOOKUP, 10'h3FF, phase_keys[7]);
        queue_word(CMD_LOOKUP, 10'h155, phase_keys[3]);
        queue_word(CMD_LOOKUP, 10'h2AA, phase_keys[6]);
        queue_word(CMD_LOOKUP, 10'h001, 48'h0000_0000_0001);
        queue_word(CMD_LOOKUP, 10'h200, 48'h8000_0000_0000);

        // linear search, address wraps
        set_regs(16'hFFFF, 8'd255, 12'hFF8);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[7]);
        queue_word(CMD_LOOKUP, 10'h000, 48'h1234_5678_9ABD);

        set_regs(16'h8000, 8'd0, 12'd1);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[0]);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[1]);

        wait_idle();
        write_reg(REG_SPARE, 16'($urandom()));
        write_reg(REG_ENTRY_COUNT, 16'hFFFF);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[0]);
        queue_word(CMD_LOOKUP, 10'h000, phase_keys[5]);

        // whole store sorted, then counts at and beyond its size
        wait_idle();
        sender_idle_pct = 27;
        fill_sorted(MAX_ENTRIES, 1'b1);
        for (i = 0; i < MAX_ENTRIES; i++)
            queue_word(CMD_LOAD, 10'(i), phase_keys[i]);
        set_regs(16'($urandom()), 8'($urandom_range(255, 6)), 12'd1024);
        repeat (10) queue_word(CMD_LOOKUP, 10'($urandom()), pick_probe(MAX_ENTRIES));
        set_regs(base_q, stride_q, 12'd2047);
        repeat (6) queue_word(CMD_LOOKUP, 10'($urandom()), pick_probe(MAX_ENTRIES));
        set_regs(base_q, stride_q, 12'hC00);
        repeat (3) queue_word(CMD_LOOKUP, 10'($urandom()), pick_probe(MAX_ENTRIES));
        set_regs(base_q, stride_q, 12'h800);
        repeat (3) queue_word(CMD_LOOKUP, 10'($urandom()), pick_probe(MAX_ENTRIES));

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 80)
                n = $urandom_range(24, 1);
            else if (r < 97)
                n = $urandom_range(128, 25);
            else
                n = $urandom_range(400, 129);

            // sorted for binary search, or unsorted with repeats
            kind = $urandom_range(99);
            if (kind < 50)
                fill_sorted(n, $urandom_range(3) == 0);
            else
                for (i = 0; i < n; i++)
                    phase_keys[i] = (i > 0 && $urandom_range(3) == 0) ?
                                    phase_keys[$urandom_range(i - 1)] : rand_key();

            if (kind >= 50 && kind < 85)
                cnt = ($urandom_range(19) == 0) ? 12'd0 : 12'(-n);
            else
                cnt = ($urandom_range(6) == 0) ? 12'($urandom_range(2047, n)) : 12'(n);

            r = $urandom_range(9);
            base = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
            r = $urandom_range(19);
            if (r < 2)
                stride = 8'd6;
            else if (r < 4)
                stride = 8'd255;
            else if (r < 5)
                stride = 8'($urandom_range(5));
            else
                stride = 8'($urandom_range(255, 6));

            set_regs(base, stride, cnt);
            case (phase % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 74;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 27;
            endcase

            for (i = 0; i < n; i++)
                queue_word(CMD_LOAD, 10'(i), phase_keys[i]);
            m = $urandom_range(30, 8);
            repeat (m)
            begin
                if ($urandom_range(19) == 0)
                    queue_word(CMD_LOAD, 10'($urandom()), rand_key());
                else
                    queue_word(CMD_LOOKUP, 10'($urandom()), pick_probe(n));
            end
            phase++;
        end

        wait_idle();
        repeat (1100) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
